/* rtl/core/cnc_pkg.sv */
// Shared types and constants for the common-neighbour counter.
package cnc_pkg;

    // Default node count of the adjacency store
    localparam int NODES_DEFAULT = 64;

    // Field widths
    localparam int OP_W  = 2;
    localparam int ID_W  = 8;
    localparam int CNT_W = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

    // Status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_BAD_ID = 1'b1;

    // Input transaction
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] node_a;
        logic [ID_W-1:0] node_b;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic [CNT_W-1:0] common_count;
        logic [CNT_W-1:0] degree_a;
        logic [CNT_W-1:0] degree_b;
        logic             status;
    } result_t;

endpackage

/* rtl/core/cnc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cnc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/common_neighbour_counter_unit.sv */
// Top level of the common-neighbour counter: adjacency store, sequencer, popcount unit.
//
// Holds a directed adjacency bitmap of NODES rows, one row per source node, in a
// single RAM with one write and one registered read port; a valid bit per row,
// cleared by reset and by a clear transaction, makes an unwritten row
// read as zero, so there is no clearing pass. One transaction is in work at a time:
// an add-edge passes through row read, write back and result load; a clear, an unused
// op or a rejected id goes straight to result load; a query reads row a, reads row b,
// counts, then loads the result. The length of a query is set by the two reads through the
// single RAM read port and by the one 8-bit popcount adder, which walks the
// degree of row a, the degree of row b and their AND one byte per cycle. Input stall
// is high while a transaction is in work; a finished result sits in the output
// register, and the next transaction is accepted while it waits to be taken.
module common_neighbour_counter_unit #(
    parameter int NODES = cnc_pkg::NODES_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  cnc_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output cnc_pkg::result_t result
);

    localparam int AW     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int NCHUNK = (NODES + 7) / 8;
    localparam int PADW   = NCHUNK * 8;
    localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam logic [cnc_pkg::ID_W-1:0] NODES_ID = cnc_pkg::ID_W'(NODES);
    localparam logic [CIW-1:0] LAST_CHUNK = CIW'(NCHUNK - 1);

    // Popcount operand select
    localparam logic [1:0] SEL_DEG_A  = 2'd0;
    localparam logic [1:0] SEL_DEG_B  = 2'd1;
    localparam logic [1:0] SEL_COMMON = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RDA  = 6'b000010,
        ST_RDB  = 6'b000100,
        ST_CNT  = 6'b001000,
        ST_WR   = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    state_t                   state_reg, state_next;
    logic [cnc_pkg::OP_W-1:0] op_reg, op_next;
    logic [AW-1:0]            a_reg, a_next;
    logic [AW-1:0]            b_reg, b_next;
    logic                     bad_reg, bad_next;
    logic [NODES-1:0]         row_valid_reg, row_valid_next;
    logic [NODES-1:0]         ra_reg, ra_next;
    logic [NODES-1:0]         rb_reg, rb_next;
    logic [1:0]               sel_reg, sel_next;
    logic [CIW-1:0]           chunk_reg, chunk_next;
    logic [cnc_pkg::CNT_W-1:0] deg_a_reg, deg_a_next;
    logic [cnc_pkg::CNT_W-1:0] deg_b_reg, deg_b_next;
    logic [cnc_pkg::CNT_W-1:0] common_reg, common_next;
    cnc_pkg::result_t         result_reg, result_next;
    logic                     result_valid_reg, result_valid_next;

    logic                     accept;
    logic                     bad_in;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [NODES-1:0]         rd_data;
    logic                     wr_en;
    logic [NODES-1:0]         wr_data;
    logic [NODES-1:0]         base_row;
    logic [NODES-1:0]         operand;
    logic [PADW-1:0]          operand_pad;
    logic [7:0]               chunk_bits;
    logic [cnc_pkg::CNT_W-1:0] acc_sel;
    logic [cnc_pkg::CNT_W-1:0] acc_sum;
    logic                     out_free;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && (state_reg == ST_IDLE);
    assign bad_in       = (item.node_a >= NODES_ID) || (item.node_b >= NODES_ID);
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Row read: source row at acceptance, second row of a query after that
    assign rd_en = (accept && !bad_in &&
                    (item.op inside {cnc_pkg::OP_ADD_EDGE, cnc_pkg::OP_QUERY}))
                   || (state_reg == ST_RDA);
    assign rd_addr = (state_reg == ST_IDLE) ? item.node_a[AW-1:0] : b_reg;

    // Edge write-back: read row (zero if never written) with the target bit set
    assign base_row = row_valid_reg[a_reg] ? rd_data : '0;
    assign wr_en    = (state_reg == ST_WR);
    assign wr_data  = base_row | (NODES'(1) << b_reg);

    cnc_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_cnc_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (a_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared popcount unit: one byte of the selected operand per cycle
    always_comb
    begin
        case (sel_reg)
            SEL_DEG_A: begin operand = ra_reg;          acc_sel = deg_a_reg;  end
            SEL_DEG_B: begin operand = rb_reg;          acc_sel = deg_b_reg;  end
            default:   begin operand = ra_reg & rb_reg; acc_sel = common_reg; end
        endcase
        operand_pad = PADW'(operand);
        chunk_bits  = operand_pad[{chunk_reg, 3'b000} +: 8];
        acc_sum     = acc_sel + cnc_pkg::CNT_W'(popcount8(chunk_bits));
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        bad_next          = bad_reg;
        row_valid_next    = row_valid_reg;
        ra_next           = ra_reg;
        rb_next           = rb_reg;
        sel_next          = sel_reg;
        chunk_next        = chunk_reg;
        deg_a_next        = deg_a_reg;
        deg_b_next        = deg_b_reg;
        common_next       = common_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = item.op;
                    a_next      = item.node_a[AW-1:0];
                    b_next      = item.node_b[AW-1:0];
                    bad_next    = bad_in;
                    deg_a_next  = '0;
                    deg_b_next  = '0;
                    common_next = '0;
                    sel_next    = SEL_DEG_A;
                    chunk_next  = '0;
                    if (!bad_in && (item.op == cnc_pkg::OP_ADD_EDGE))
                    begin
                        state_next = ST_WR;
                    end
                    else if (!bad_in && (item.op == cnc_pkg::OP_QUERY))
                    begin
                        state_next = ST_RDA;
                    end
                    else
                    begin
                        if (item.op == cnc_pkg::OP_CLEAR)
                        begin
                            row_valid_next = '0;
                        end
                        state_next = ST_OUT;
                    end
                end
            end
            ST_RDA:
            begin
                ra_next    = row_valid_reg[a_reg] ? rd_data : '0;
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                rb_next    = row_valid_reg[b_reg] ? rd_data : '0;
                state_next = ST_CNT;
            end
            ST_CNT:
            begin
                case (sel_reg)
                    SEL_DEG_A: deg_a_next  = acc_sum;
                    SEL_DEG_B: deg_b_next  = acc_sum;
                    default:   common_next = acc_sum;
                endcase
                if (chunk_reg == LAST_CHUNK)
                begin
                    chunk_next = '0;
                    if (sel_reg == SEL_COMMON)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                    end
                end
                else
                begin
                    chunk_next = chunk_reg + CIW'(1);
                end
            end
            ST_WR:
            begin
                row_valid_next[a_reg] = 1'b1;
                state_next            = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    result_next.common_count = common_reg;
                    result_next.degree_a     = deg_a_reg;
                    result_next.degree_b     = deg_b_reg;
                    result_next.status       =
                        (bad_reg &&
                         (op_reg inside {cnc_pkg::OP_ADD_EDGE, cnc_pkg::OP_QUERY}))
                        ? cnc_pkg::STATUS_BAD_ID : cnc_pkg::STATUS_OK;
                    result_valid_next        = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            row_valid_reg    <= '0;
            result_valid_reg <= 1'b0;
            sel_reg          <= SEL_DEG_A;
            chunk_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            row_valid_reg    <= row_valid_next;
            result_valid_reg <= result_valid_next;
            sel_reg          <= sel_next;
            chunk_reg        <= chunk_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        bad_reg    <= bad_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        deg_a_reg  <= deg_a_next;
        deg_b_reg  <= deg_b_next;
        common_reg <= common_next;
        result_reg <= result_next;
    end

endmodule

/* rtl/core/cnc_checker.sv */
// Port-level assertions for the common-neighbour counter, bound to the top level.
module cnc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input cnc_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input cnc_pkg::result_t result
);

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

    // A rejected id reports no counts
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == cnc_pkg::STATUS_BAD_ID) |->
        (result.common_count == '0) && (result.degree_a == '0) && (result.degree_b == '0))
    else $error("counts reported with bad id status");

    // The shared count never exceeds either degree
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
        (result.common_count <= result.degree_a) && (result.common_count <= result.degree_b))
    else $error("common count above a degree");

    // An accepted transaction keeps the input stalled in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
    else $error("input not stalled after acceptance");

endmodule

bind common_neighbour_counter_unit cnc_checker u_cnc_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for the common-neighbour counter unit.
module testbench;
    import cnc_pkg::*;

    localparam int NODES       = NODES_DEFAULT;
    localparam int ITEM_COUNT  = 850;
    localparam int TAIL_CYCLES = 40;
    localparam int IDLE_PCT    = 6;
    // Window of transaction counts in which neither side idles
    localparam int CALM_LO     = 300;
    localparam int CALM_HI     = 450;

    // Op code the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic    clk;
    logic    rst_n;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Predicted adjacency store, one row per source node
    logic [63:0] adj_rows [NODES] = '{default: '0};

    item_t   stimulus[$];
    result_t pending_results[$];

    logic taken_q;
    int   sent_count    = 0;
    int   checked_count = 0;
    int   fault_count   = 0;

    common_neighbour_counter_unit #(
        .NODES(NODES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic item_t make_item(input int op, input int a, input int b);
        item_t it;
        it.op     = OP_W'(op);
        it.node_a = ID_W'(a);
        it.node_b = ID_W'(b);
        return it;
    endfunction

    // Append one transaction to the stimulus queue
    task automatic queue_item(input int op, input int a, input int b);
        stimulus.insert(stimulus.size(), make_item(op, a, b));
    endtask

    // Apply one transaction to the predicted store and return its result
    function automatic result_t apply_item(input item_t it);
        result_t     r;
        logic        bad_id;
        logic [63:0] row_a;
        logic [63:0] row_b;
        r      = '0;
        bad_id = (it.node_a >= NODES) || (it.node_b >= NODES);
        case (it.op)
            OP_ADD_EDGE:
            begin
                if (bad_id)
                    r.status = STATUS_BAD_ID;
                else
                    adj_rows[it.node_a] = adj_rows[it.node_a] | (64'd1 << it.node_b);
            end
            OP_QUERY:
            begin
                if (bad_id)
                    r.status = STATUS_BAD_ID;
                else
                begin
                    row_a          = adj_rows[it.node_a];
                    row_b          = adj_rows[it.node_b];
                    r.common_count = CNT_W'($countones(row_a & row_b));
                    r.degree_a     = CNT_W'($countones(row_a));
                    r.degree_b     = CNT_W'($countones(row_b));
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NODES; i++)
                    adj_rows[i] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fault_count++;
        end
    endtask

    // Driver: new transaction or idle at the falling edge; a stalled one is held
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || taken_q)
            begin
                if (stimulus.size() != 0 &&
                    ((sent_count >= CALM_LO && sent_count < CALM_HI) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    item       <= stimulus.pop_front();
                    item_valid <= 1'b1;
                    sent_count <= sent_count + 1;
                end
                else
                    item_valid <= 1'b0;
            end
            result_stall <= !(checked_count >= CALM_LO && checked_count < CALM_HI) &&
                            ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Monitor: check results, then predict for each accepted transaction
    always @(posedge clk)
    begin : monitor
        result_t exp_r;
        if (!rst_n)
            taken_q <= 1'b0;
        else
        begin
            taken_q <= item_valid && !item_stall;
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with no expectation pending");
                    fault_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    check_field("common_count", int'(exp_r.common_count),
                                int'(result.common_count));
                    check_field("degree_a", int'(exp_r.degree_a), int'(result.degree_a));
                    check_field("degree_b", int'(exp_r.degree_b), int'(result.degree_b));
                    check_field("status", int'(exp_r.status), int'(result.status));
                    checked_count++;
                end
            end
            if (item_valid && !item_stall)
                pending_results.insert(pending_results.size(), apply_item(item));
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : sequencer
        int span;
        int srcs;
        int len;
        int pick;
        int n;
        rst_n = 1'b0;

        // Directed: corner ids, repeated edge, bad ids, unused op, clear
        queue_item(OP_ADD_EDGE, 0, 0);
        queue_item(OP_ADD_EDGE, 0, NODES - 1);
        queue_item(OP_ADD_EDGE, NODES - 1, 0);
        queue_item(OP_ADD_EDGE, NODES - 1, NODES - 1);
        queue_item(OP_ADD_EDGE, 0, NODES - 1);
        queue_item(OP_ADD_EDGE, 5, NODES - 1);
        queue_item(OP_QUERY, 0, NODES - 1);
        queue_item(OP_QUERY, 0, 0);
        queue_item(OP_QUERY, NODES - 1, 5);
        queue_item(OP_ADD_EDGE, NODES, 0);
        queue_item(OP_ADD_EDGE, 0, NODES);
        queue_item(OP_ADD_EDGE, 255, 255);
        queue_item(OP_QUERY, 255, 0);
        queue_item(OP_QUERY, 0, 128);
        queue_item(OP_QUERY, NODES, NODES);
        queue_item(OP_UNUSED, 255, 255);
        queue_item(OP_UNUSED, 0, 0);
        queue_item(OP_QUERY, 1, 2);
        queue_item(OP_CLEAR, 0, 0);
        queue_item(OP_QUERY, 0, NODES - 1);
        queue_item(OP_ADD_EDGE, 170, 85);
        queue_item(OP_ADD_EDGE, 42, 21);
        queue_item(OP_QUERY, 42, 21);
        queue_item(OP_CLEAR, 255, 255);
        queue_item(OP_QUERY, 42, 42);

        // Random phases: edges and queries over a node subset, in half of them with
        // one to three sources so that rows fill up; some noise mixed in
        n = 0;
        while (n < ITEM_COUNT)
        begin
            span = 8 << $urandom_range(0, 3);
            if (span > NODES)
                span = NODES;
            srcs = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, span);
            len  = $urandom_range(20, 80);
            repeat (len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    queue_item(OP_ADD_EDGE, $urandom_range(0, srcs - 1),
                               $urandom_range(0, span - 1));
                else if (pick < 86)
                    queue_item(OP_QUERY, $urandom_range(0, srcs - 1),
                               $urandom_range(0, span - 1));
                else if (pick < 91)
                begin
                    if ($urandom_range(0, 1))
                        queue_item($urandom_range(0, 1), $urandom_range(NODES, 255),
                                   $urandom_range(0, 255));
                    else
                        queue_item($urandom_range(0, 1), $urandom_range(0, 255),
                                   $urandom_range(NODES, 255));
                end
                else if (pick < 94)
                    queue_item(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255));
                else if (pick < 95)
                    queue_item(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
                else
                    queue_item($urandom_range(0, 3), $urandom_range(0, 255),
                               $urandom_range(0, 255));
                n++;
            end
        end

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Drain: everything sent and every expected result seen
        while (stimulus.size() != 0 || item_valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fault_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/cnc_pkg.sv
rtl/core/cnc_ram.sv
rtl/core/common_neighbour_counter_unit.sv
rtl/core/cnc_checker.sv
dv/testbench.sv
